@@ rtl/lpi_pkg.sv @@
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared constants and pipeline types for the line/plane intersection block.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int CoordW   = 32;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = CoordW + DiffW;
  localparam int SumW     = ProdW + 2;
  localparam int QuotW    = 64;
  localparam int DivSteps = QuotW;
  localparam int ThrW     = 63;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 64;

  localparam logic [ThrW-1:0] THR_RESET = 63'd42950;
  localparam logic            REG_THR   = 1'b0;

  localparam logic [QuotW-1:0] T_MAX = {1'b0, {(QuotW-1){1'b1}}};
  localparam logic [QuotW-1:0] T_MIN = {1'b1, {(QuotW-1){1'b0}}};

  typedef struct packed {
    logic                         hit;
    logic                         neg;
    logic                         ovf;
    logic [SumW-1:0]              mden;
    logic [SumW-1:0]              rem;
    logic [QuotW-1:0]             dq;
    logic [2:0][CoordW-1:0]       p1;
    logic [2:0][DiffW-1:0]        d;
  } div_t;

  typedef struct packed {
    logic                   hit;
    logic [2:0][CoordW-1:0] pt;
  } res_t;

endpackage

@@ rtl/lpi_in_if.sv @@
// ----------------------------------------------------------------------------
// lpi_in_if
// Query channel: line endpoints, plane point and plane normal.
// ----------------------------------------------------------------------------
interface lpi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic signed [31:0] plane_px;
  logic signed [31:0] plane_py;
  logic signed [31:0] plane_pz;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  plane_px, plane_py, plane_pz, normal_x, normal_y, normal_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                plane_px, plane_py, plane_pz, normal_x, normal_y, normal_z,
                output ready);
endinterface

@@ rtl/lpi_out_if.sv @@
// ----------------------------------------------------------------------------
// lpi_out_if
// Result channel: intersection point and hit flag.
// ----------------------------------------------------------------------------
interface lpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;
  logic               hit;

  modport source (output valid, hit_x, hit_y, hit_z, hit, input ready);
  modport sink (input valid, hit_x, hit_y, hit_z, hit, output ready);
endinterface

@@ rtl/line_plane_intersection.sv @@
// ----------------------------------------------------------------------------
// line_plane_intersection
// Pipelined line/plane intersection in Q16.16 with a 64-stage divider.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      start, end, plane point, normal (x/y/z)
//   rsp      out  valid/ready      hit_x, hit_y, hit_z, hit
//   apb      in   psel/penable     parallel_threshold at address 0
//
// One transaction per cycle while the skid register is empty; the divider
// yields one quotient bit per stage. Synchronous reset clears all valid
// bits and loads the threshold reset value. A stall on rsp fills a
// one-entry skid register first; the pipeline then freezes as a whole.
// ----------------------------------------------------------------------------
module line_plane_intersection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpi_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lpi_pkg::CfgDataW-1:0]  pwdata,
  output logic [lpi_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  lpi_in_if.sink                        req,
  lpi_out_if.source                     rsp
);
  import lpi_pkg::*;

  logic            en;
  logic [ThrW-1:0] thr;
  logic            vld [DivSteps+1];
  div_t            stg [DivSteps+1];
  logic            last_vld;
  res_t            last;
  logic            skid_vld;
  res_t            skid;
  res_t            cur;

  assign pready = 1'b1;
  assign en     = !skid_vld;

  lpi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .thr
  );

  lpi_front u_front (
    .clk, .rst, .en, .thr, .req, .vld(vld[0]), .dat(stg[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    lpi_div_step u_step (
      .clk, .rst, .en,
      .vld_i(vld[g]), .dat_i(stg[g]), .vld_o(vld[g+1]), .dat_o(stg[g+1])
    );
  end

  lpi_back u_back (
    .clk, .rst, .en,
    .vld_i(vld[DivSteps]), .dat_i(stg[DivSteps]), .vld_o(last_vld), .dat_o(last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (en && last_vld && !rsp.ready) begin
      skid_vld <= 1'b1;
    end else if (skid_vld && rsp.ready) begin
      skid_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last_vld && !rsp.ready) begin
      skid <= last;
    end
  end

  assign cur       = skid_vld ? skid : last;
  assign rsp.valid = skid_vld || last_vld;
  assign rsp.hit_x = cur.pt[0];
  assign rsp.hit_y = cur.pt[1];
  assign rsp.hit_z = cur.pt[2];
  assign rsp.hit   = cur.hit;

`ifndef SYNTHESIS
  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    (skid_vld && !rsp.ready) |=> (skid_vld && $stable(skid)))
    else $error("skid entry lost");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (skid_vld && last_vld) |=> (last_vld && $stable(last)))
    else $error("pipeline moved while skid full");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> (rsp.hit_x == 0 && rsp.hit_y == 0 && rsp.hit_z == 0))
    else $error("miss with nonzero point");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> !req.ready)
    else $error("input taken while skid full");
`endif
endmodule

@@ rtl/lpi_cfg.sv @@
// ----------------------------------------------------------------------------
// lpi_cfg
// APB register file holding the parallel threshold.
// ----------------------------------------------------------------------------
module lpi_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpi_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lpi_pkg::CfgDataW-1:0]  pwdata,
  output logic [lpi_pkg::CfgDataW-1:0]  prdata,
  output logic [lpi_pkg::ThrW-1:0]      thr
);
  import lpi_pkg::*;

  logic sel_thr;

  assign sel_thr = (paddr[CfgAddrW-1] == REG_THR) && (paddr[CfgAddrW-2:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && sel_thr) begin
      thr <= pwdata[ThrW-1:0];
    end
  end

  assign prdata = sel_thr ? {{(CfgDataW-ThrW){1'b0}}, thr} : '0;
endmodule

@@ rtl/lpi_front.sv @@
// ----------------------------------------------------------------------------
// lpi_front
// Differences, dot products, magnitudes, hit test and divider setup.
// ----------------------------------------------------------------------------
module lpi_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [lpi_pkg::ThrW-1:0] thr,
  lpi_in_if.sink                   req,
  output logic                     vld,
  output lpi_pkg::div_t            dat
);
  import lpi_pkg::*;

  logic signed [CoordW-1:0] s_in [3];
  logic signed [CoordW-1:0] e_in [3];
  logic signed [CoordW-1:0] q_in [3];
  logic signed [CoordW-1:0] n_in [3];

  logic                     vld_a, vld_b, vld_c;
  logic signed [CoordW-1:0] p1_a [3];
  logic signed [DiffW-1:0]  d_a [3];
  logic signed [DiffW-1:0]  w_a [3];
  logic signed [CoordW-1:0] n_a [3];

  logic signed [CoordW-1:0] p1_b [3];
  logic signed [DiffW-1:0]  d_b [3];
  logic signed [ProdW-1:0]  pd_b [3];
  logic signed [ProdW-1:0]  pw_b [3];

  logic signed [CoordW-1:0] p1_c [3];
  logic signed [DiffW-1:0]  d_c [3];
  logic signed [SumW-1:0]   den_c;
  logic signed [SumW-1:0]   num_c;

  logic [SumW-1:0] mden, mnum;
  div_t            dat_next;

  assign req.ready = en;

  assign s_in[0] = req.start_x;  assign s_in[1] = req.start_y;  assign s_in[2] = req.start_z;
  assign e_in[0] = req.end_x;    assign e_in[1] = req.end_y;    assign e_in[2] = req.end_z;
  assign q_in[0] = req.plane_px; assign q_in[1] = req.plane_py; assign q_in[2] = req.plane_pz;
  assign n_in[0] = req.normal_x; assign n_in[1] = req.normal_y; assign n_in[2] = req.normal_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld   <= 1'b0;
    end else if (en) begin
      vld_a <= req.valid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld   <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_a[i] <= s_in[i];
        d_a[i]  <= DiffW'(e_in[i]) - DiffW'(s_in[i]);
        w_a[i]  <= DiffW'(s_in[i]) - DiffW'(q_in[i]);
        n_a[i]  <= n_in[i];

        p1_b[i] <= p1_a[i];
        d_b[i]  <= d_a[i];
        pd_b[i] <= ProdW'(n_a[i] * d_a[i]);
        pw_b[i] <= ProdW'(n_a[i] * w_a[i]);

        p1_c[i] <= p1_b[i];
        d_c[i]  <= d_b[i];
      end
      den_c <= SumW'(pd_b[0]) + SumW'(pd_b[1]) + SumW'(pd_b[2]);
      num_c <= SumW'(pw_b[0]) + SumW'(pw_b[1]) + SumW'(pw_b[2]);
      dat   <= dat_next;
    end
  end

  always_comb begin
    mden = den_c[SumW-1] ? SumW'(-den_c) : den_c;
    mnum = num_c[SumW-1] ? SumW'(-num_c) : num_c;
    dat_next.hit  = mden > {{(SumW-ThrW){1'b0}}, thr};
    dat_next.neg  = den_c[SumW-1] == num_c[SumW-1];
    dat_next.ovf  = {32'b0, mnum} >= {mden, 32'b0};
    dat_next.mden = mden;
    dat_next.rem  = {32'b0, mnum[SumW-1:32]};
    dat_next.dq   = {mnum[31:0], 32'b0};
    for (int i = 0; i < 3; i++) begin
      dat_next.p1[i] = p1_c[i];
      dat_next.d[i]  = d_c[i];
    end
  end
endmodule

@@ rtl/lpi_div_step.sv @@
// ----------------------------------------------------------------------------
// lpi_div_step
// One restoring-division stage: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lpi_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  lpi_pkg::div_t dat_i,
  output logic          vld_o,
  output lpi_pkg::div_t dat_o
);
  import lpi_pkg::*;

  logic [SumW:0] rsh;
  logic          ge;
  div_t          dat_next;

  always_comb begin
    rsh = {dat_i.rem, dat_i.dq[QuotW-1]};
    ge  = rsh >= {1'b0, dat_i.mden};
    dat_next     = dat_i;
    dat_next.rem = ge ? SumW'(rsh - {1'b0, dat_i.mden}) : rsh[SumW-1:0];
    dat_next.dq  = {dat_i.dq[QuotW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_o <= dat_next;
    end
  end
endmodule

@@ rtl/lpi_back.sv @@
// ----------------------------------------------------------------------------
// lpi_back
// Quotient saturation, t*d split products, offset add, miss zeroing and Q16.16 saturation.
// ----------------------------------------------------------------------------
module lpi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  lpi_pkg::div_t dat_i,
  output logic          vld_o,
  output lpi_pkg::res_t dat_o
);
  import lpi_pkg::*;

  localparam int HiW = CoordW + DiffW;
  localparam int LoW = DiffW + DiffW;
  localparam int AccW = HiW + 2;

  logic                     vld_e, vld_f;
  logic [QuotW-1:0]         t_next, t_e;
  logic                     hit_e, hit_f;
  logic signed [CoordW-1:0] p1_e [3];
  logic signed [DiffW-1:0]  d_e [3];
  logic signed [CoordW-1:0] p1_f [3];
  logic signed [HiW-1:0]    ph_f [3];
  logic signed [LoW-1:0]    pl_f [3];
  logic signed [AccW-1:0]   v [3];
  res_t                     res_next;

  always_comb begin
    if (dat_i.ovf) begin
      t_next = dat_i.neg ? T_MIN : T_MAX;
    end else if (dat_i.neg) begin
      t_next = (dat_i.dq > T_MIN) ? T_MIN : QuotW'(-dat_i.dq);
    end else begin
      t_next = (dat_i.dq > T_MAX) ? T_MAX : dat_i.dq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_e <= 1'b0;
      vld_f <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld_e <= vld_i;
      vld_f <= vld_e;
      vld_o <= vld_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_e   <= t_next;
      hit_e <= dat_i.hit;
      hit_f <= hit_e;
      for (int i = 0; i < 3; i++) begin
        p1_e[i] <= dat_i.p1[i];
        d_e[i]  <= dat_i.d[i];
        p1_f[i] <= p1_e[i];
        ph_f[i] <= HiW'($signed(t_e[QuotW-1:32]) * d_e[i]);
        pl_f[i] <= LoW'($signed({1'b0, t_e[31:0]}) * d_e[i]);
      end
      dat_o <= res_next;
    end
  end

  always_comb begin
    res_next.hit = hit_f;
    for (int i = 0; i < 3; i++) begin
      v[i] = AccW'(ph_f[i]) + AccW'(pl_f[i] >>> 32) + AccW'(p1_f[i]);
      if (!hit_f) begin
        res_next.pt[i] = '0;
      end else if (v[i] > AccW'(32'sh7fffffff)) begin
        res_next.pt[i] = 32'h7fffffff;
      end else if (v[i] < -AccW'(33'sh080000000)) begin
        res_next.pt[i] = 32'h80000000;
      end else begin
        res_next.pt[i] = v[i][CoordW-1:0];
      end
    end
  end
endmodule
